FILE: hdl/mm4_pkg.sv
package mm4_pkg;

  localparam int DIM     = 4;
  localparam int CELLS   = 16;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [1:0] CMD_WRITE_A  = 2'd0;
  localparam logic [1:0] CMD_WRITE_B  = 2'd1;
  localparam logic [1:0] CMD_MULTIPLY = 2'd2;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(CELLS - 1);

  typedef struct packed {
    logic [1:0]                cmd;
    logic [INDEX_W-1:0]        element_index;
    logic signed [VALUE_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        out_index;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_WRITE_A,
    OP_WRITE_B,
    OP_MULTIPLY
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

endpackage

FILE: hdl/mm4_front.sv
module mm4_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mm4_pkg::in_item_t in_item,
  output logic              q_valid,
  output mm4_pkg::q_entry_t q_entry,
  input  logic              q_pop
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  mm4_pkg::q_entry_t   queue_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                known;
  logic                push;
  mm4_pkg::q_entry_t   entry;

  always_comb begin
    known       = 1'b1;
    entry.index = in_item.element_index;
    entry.value = in_item.element_value;
    case (in_item.cmd)
      mm4_pkg::CMD_WRITE_A:  entry.op = mm4_pkg::OP_WRITE_A;
      mm4_pkg::CMD_WRITE_B:  entry.op = mm4_pkg::OP_WRITE_B;
      mm4_pkg::CMD_MULTIPLY: entry.op = mm4_pkg::OP_MULTIPLY;
      default: begin
        entry.op = mm4_pkg::OP_MULTIPLY;
        known    = 1'b0;
      end
    endcase
  end

  assign in_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count_r != '0);
  assign q_entry  = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !(q_pop && q_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

endmodule

FILE: hdl/mm4_back.sv
module mm4_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mm4_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mm4_pkg::out_item_t out_item
);

  localparam int VW = mm4_pkg::VALUE_W;
  localparam int PW = mm4_pkg::PROD_W;
  localparam int AW = mm4_pkg::ACC_W;
  localparam int IW = mm4_pkg::INDEX_W;

  mm4_pkg::back_state_t state_r, state_nxt;

  logic signed [VW-1:0] a_store_r [mm4_pkg::CELLS];
  logic signed [VW-1:0] b_store_r [mm4_pkg::CELLS];

  logic [IW-1:0]        elem_r, elem_nxt;
  logic [1:0]           k_r, k_nxt;
  logic signed [VW-1:0] opa_r, opb_r;
  logic                 s1_valid_r, s1_last_r;
  logic signed [PW-1:0] prod_r;
  logic                 s2_valid_r, s2_last_r;
  logic signed [AW-1:0] acc_r;
  logic                 done_r;
  logic                 out_valid_r;
  mm4_pkg::out_item_t   out_item_r;

  logic                 slot_free;
  logic                 wr_a, wr_b, start, issue, emit;
  logic [IW-1:0]        a_addr, b_addr;
  logic signed [AW-1:0] shifted;
  logic signed [VW-1:0] sat_value;

  assign slot_free = !out_valid_r || out_ready;
  assign a_addr    = {k_r, elem_r[1:0]};
  assign b_addr    = {elem_r[3:2], k_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm4_pkg::BK_IDLE: begin
        if (q_valid && q_entry.op == mm4_pkg::OP_MULTIPLY) begin
          state_nxt = mm4_pkg::BK_ISSUE;
        end
      end
      mm4_pkg::BK_ISSUE: begin
        if (k_r == 2'd3) begin
          state_nxt = mm4_pkg::BK_DRAIN;
        end
      end
      mm4_pkg::BK_DRAIN: begin
        if (done_r && slot_free) begin
          state_nxt = (elem_r == mm4_pkg::LAST_INDEX) ? mm4_pkg::BK_IDLE : mm4_pkg::BK_ISSUE;
        end
      end
      default: state_nxt = mm4_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    start = 1'b0;
    issue = 1'b0;
    emit  = 1'b0;
    case (state_r)
      mm4_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_entry.op)
            mm4_pkg::OP_WRITE_A: wr_a = 1'b1;
            mm4_pkg::OP_WRITE_B: wr_b = 1'b1;
            default:             start = 1'b1;
          endcase
        end
      end
      mm4_pkg::BK_ISSUE: issue = 1'b1;
      mm4_pkg::BK_DRAIN: emit  = done_r && slot_free;
      default: ;
    endcase
  end

  always_comb begin
    elem_nxt = elem_r;
    k_nxt    = k_r;
    if (start) begin
      elem_nxt = '0;
      k_nxt    = '0;
    end else if (issue) begin
      k_nxt = k_r + 1'b1;
    end else if (emit) begin
      elem_nxt = elem_r + 1'b1;
      k_nxt    = '0;
    end
  end

  assign shifted = acc_r >>> FRAC_BITS;

  always_comb begin
    if (shifted[AW-1:VW-1] == '0 || shifted[AW-1:VW-1] == '1) begin
      sat_value = shifted[VW-1:0];
    end else if (shifted[AW-1]) begin
      sat_value = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mm4_pkg::BK_IDLE;
      elem_r      <= '0;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      elem_r     <= elem_nxt;
      k_r        <= k_nxt;
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      if (issue && k_r == 2'd0) begin
        done_r <= 1'b0;
      end else if (s2_valid_r && s2_last_r) begin
        done_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mm4_pkg::CELLS; i++) begin
        a_store_r[i] <= '0;
        b_store_r[i] <= '0;
      end
    end else begin
      if (wr_a) begin
        a_store_r[q_entry.index] <= q_entry.value;
      end
      if (wr_b) begin
        b_store_r[q_entry.index] <= q_entry.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    opa_r     <= a_store_r[a_addr];
    opb_r     <= b_store_r[b_addr];
    s1_last_r <= (k_r == 2'd3);
    prod_r    <= opa_r * opb_r;
    s2_last_r <= s1_last_r;
    if (issue && k_r == 2'd0) begin
      acc_r <= '0;
    end else if (s2_valid_r) begin
      acc_r <= acc_r + {{(AW-PW){prod_r[PW-1]}}, prod_r};
    end
    if (emit) begin
      out_item_r.out_index <= elem_r;
      out_item_r.out_value <= sat_value;
      out_item_r.last      <= (elem_r == mm4_pkg::LAST_INDEX);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hdl/matrix_multiply_4x4.sv
// 4x4 signed fixed-point matrix multiplier, product B times A.
// Input channel (in_valid / in_ready / in_item): one request per element
// load (cmd 0 loads A, cmd 1 loads B, at element_index) or one multiply
// request (cmd 2). Unused command codes are taken and dropped.
// Result channel (out_valid / out_ready / out_item): a multiply request
// gives sixteen results, index 0 to 15, the last one flagged.
// A four-entry request queue sits in front of the execution unit; loads
// are taken one per cycle while it has room.
// A load is written in the execution unit when it leaves the queue. A multiply
// runs one 32x32 multiplier over the four terms of each element: the terms
// pass the operand, product and accumulator registers, and the next element
// starts only once the sum of the last one is in the result register.
// The multiply loop sets the rate.
// Reset (synchronous, rst_n low) clears both matrices to zero, empties
// the queue and drops any pending result.
// When the receiver stalls, the result register holds its value and the
// unit waits; the queue keeps taking requests until it is full.
module matrix_multiply_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mm4_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mm4_pkg::out_item_t out_item
);

  logic              q_valid;
  logic              q_pop;
  mm4_pkg::q_entry_t q_entry;

  mm4_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  mm4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: hdl/mm4_checker.sv
module mm4_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input mm4_pkg::out_item_t out_item
);

  logic [mm4_pkg::INDEX_W-1:0] exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_item.out_index + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last == (out_item.out_index == mm4_pkg::LAST_INDEX)))
    else $error("last flag does not match index");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.out_index == exp_idx_r)
    else $error("result index out of order");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind matrix_multiply_4x4 mm4_checker u_checker (.*);

FILE: dv/product_check.sv
`timescale 1ns / 1ps

module product_check
  import mm4_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        pending
);

  localparam longint VALUE_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint VALUE_MIN = -64'sh0000_0000_8000_0000;

  logic signed [VALUE_W-1:0] a_store [CELLS];
  logic signed [VALUE_W-1:0] b_store [CELLS];
  out_item_t                 awaited_products [$];
  int                        fault_count = 0;

  function automatic logic signed [VALUE_W-1:0] product_element(int row, int col);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    longint                  term;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      term = longint'(b_store[row*DIM+k]) * longint'(a_store[k*DIM+col]);
      acc  = acc + ACC_W'(term);
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > VALUE_MAX) begin
      return VALUE_W'(VALUE_MAX);
    end else if (scaled < VALUE_MIN) begin
      return VALUE_W'(VALUE_MIN);
    end
    return VALUE_W'(scaled);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        a_store[i] = '0;
        b_store[i] = '0;
      end
      awaited_products.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_products.size() == 0) begin
          $error("unexpected result: out_index %0d, out_value %0d, last %0b",
                 out_item.out_index, out_item.out_value, out_item.last);
          fault_count++;
        end else begin
          want = awaited_products.pop_front();
          if (out_item.out_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, out_item.out_index);
            fault_count++;
          end
          if (out_item.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_item.out_value);
            fault_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item.last);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_item.cmd)
          CMD_WRITE_A: a_store[in_item.element_index] = in_item.element_value;
          CMD_WRITE_B: b_store[in_item.element_index] = in_item.element_value;
          CMD_MULTIPLY: begin
            for (int n = 0; n < CELLS; n++) begin
              want.out_index = INDEX_W'(n);
              want.out_value = product_element(n / DIM, n % DIM);
              want.last      = (n == CELLS - 1);
              awaited_products.push_back(want);
            end
          end
          default: ;
        endcase
      end
    end
    pending    <= awaited_products.size();
    mismatches <= fault_count;
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mm4_pkg::*;

  localparam int         FRAC_BITS    = 16;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         RANDOM_ITEMS = 230;
  localparam int         CALM_AFTER   = 190;
  localparam int         DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        mismatches;
  int        pending;
  int        idle_pct;
  logic      long_hold;
  int        quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  matrix_multiply_4x4 #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  product_check #(
    .FRAC_BITS(FRAC_BITS)
  ) i_product_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_request(logic [1:0] cmd, logic [INDEX_W-1:0] idx,
                                            logic [VALUE_W-1:0] val);
    in_item_t item;
    item.cmd           = cmd;
    item.element_index = idx;
    item.element_value = val;
    return item;
  endfunction

  function automatic logic [VALUE_W-1:0] element_pick();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 4))
      0: return r;
      1: return {{8{r[23]}}, r[23:0]};
      2: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          4:       return 32'h0001_0000;
          default: return 32'hffff_0000;
        endcase
      end
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  task automatic offer(input in_item_t item);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= in_item_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int loaded;
    int seq;
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    long_hold = 1'b0;
    idle_pct  = 0;
    loaded    = 0;
    seq       = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // product of the cleared stores, then an unused command
    offer(make_request(CMD_MULTIPLY, 4'd0, 32'h0000_0000));
    offer(make_request(CMD_UNUSED, 4'd7, 32'h1234_5678));
    // column 0 of A and row 0 of B at the most negative value: sum past 64 bits
    for (int k = 0; k < DIM; k++) begin
      offer(make_request(CMD_WRITE_A, INDEX_W'(k * DIM), 32'h8000_0000));
      offer(make_request(CMD_WRITE_B, INDEX_W'(k), 32'h8000_0000));
    end
    // negative overflow, rounding toward minus infinity, exact top value
    offer(make_request(CMD_WRITE_B, 4'd5, 32'h7fff_ffff));
    offer(make_request(CMD_WRITE_A, 4'd5, 32'h8000_0000));
    offer(make_request(CMD_WRITE_B, 4'd10, 32'h0000_0001));
    offer(make_request(CMD_WRITE_A, 4'd10, 32'hffff_ffff));
    offer(make_request(CMD_WRITE_B, LAST_INDEX, 32'h0001_0000));
    offer(make_request(CMD_WRITE_A, LAST_INDEX, 32'h7fff_ffff));
    // multiply with junk in the ignored fields
    offer(make_request(CMD_MULTIPLY, LAST_INDEX, 32'hffff_ffff));
    offer(make_request(CMD_UNUSED, 4'd0, 32'h0000_0000));

    while (loaded < RANDOM_ITEMS) begin
      if (loaded >= CALM_AFTER) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 25;
          default: idle_pct = 60;
        endcase
      end
      n = $urandom_range(1, 20);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) begin
          offer(make_request(CMD_UNUSED, INDEX_W'($urandom_range(0, 15)), $urandom));
        end
        offer(make_request($urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A,
                           INDEX_W'($urandom_range(0, 15)), element_pick()));
        loaded++;
      end
      // hold the result side so the request queue fills behind this multiply
      if (seq == 3) begin
        long_hold <= 1'b1;
      end
      offer(make_request(CMD_MULTIPLY, INDEX_W'($urandom_range(0, 15)), $urandom));
      loaded++;
      seq++;
    end

    in_valid <= 1'b0;
    idle_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
